// ----- hw/rtl/reply_frame_checker_assert.svh -----
// ----------------------------------------------------------------------------
// reply_frame_checker assertion macros
// Implication checks, same cycle and next cycle, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_CHECKER_ASSERT_SVH
`define REPLY_FRAME_CHECKER_ASSERT_SVH

// check that prop holds in the cycle in which cond holds
`define RFC_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("reply_frame_checker: same-cycle check failed");

// check that prop holds in the cycle after cond holds
`define RFC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("reply_frame_checker: next-cycle check failed");

`endif

// ----- hw/rtl/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, frame constants, status codes and the CRC-16 byte update shared by
// the reply frame checker and its frame judge.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam int CRC_BYTES   = 7;
    localparam int COUNT_W     = 4;
    localparam int STATUS_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT     = COUNT_W'(12);
    localparam logic [COUNT_W-1:0] COUNT_CRC_END = COUNT_W'(CRC_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_STORE   = COUNT_W'(STORE_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_FINAL   = COUNT_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [STATUS_W-1:0] ST_UNPACK_ERROR  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CRC_ERROR     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DATA_OK       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMMAND_OK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COMMAND_ERROR = 3'd4;

    localparam logic [7:0] HDR_SYNC     = 8'hff;
    localparam logic [7:0] HDR_ZERO     = 8'h00;
    localparam logic [7:0] ADDR_HOST    = 8'h00;
    localparam logic [7:0] TYPE_COMMAND = 8'h11;
    localparam logic [7:0] LEN_COMMAND  = 8'h02;
    localparam logic [7:0] RESP_OK      = 8'h01;
    localparam logic [7:0] RESP_ERROR   = 8'hfa;
    localparam logic [7:0] TRAIL_FIRST  = 8'h55;
    localparam logic [7:0] TRAIL_SECOND = 8'haa;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // byte 0 sits in the lowest element
    localparam frame_t CRC_ERR_FRAME = {8'haa, 8'h55, 8'h39, 8'h5b, 8'hfa, 8'h60,
                                        8'h02, 8'h33, 8'h00, 8'h00, 8'hff};
    localparam frame_t DATA_OK_FRAME = {8'haa, 8'h55, 8'h1c, 8'h68, 8'h01, 8'ha0,
                                        8'h02, 8'h22, 8'h00, 8'h00, 8'hff};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          command_byte;
    } verdict_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/reply_frame_checker.sv -----
// ----------------------------------------------------------------------------
// reply_frame_checker: one byte item per cycle while in_stall is low; status is
// valid after the last byte has passed the input and result registers.
// The CRC byte update and the frame compare are combinational.
// Reset clears count, CRC and valid flags; the byte store is not reset.
// ----------------------------------------------------------------------------
`include "reply_frame_checker_assert.svh"

module reply_frame_checker
    import rfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [7:0]          command_byte
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [15:0]         crc_reg;
    logic [15:0]         crc_next;
    logic [7:0]          store_reg [STORE_BYTES];
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [7:0]          command_reg;
    logic                in_accept;
    logic                out_free;
    logic                s1_advance;
    logic                emit;
    logic                is_command;
    frame_t              frame;
    verdict_t            verdict;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;
    assign emit       = s1_advance && s1_last_reg;

    // input register
    assign s1_valid_next = in_accept || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // frame accumulation
    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (s1_advance)
        begin
            if (count_reg < COUNT_CRC_END)
            begin
                crc_next = crc_byte(crc_reg, s1_byte_reg);
            end
            if (count_reg < COUNT_SAT)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (s1_last_reg)
            begin
                count_next = '0;
                crc_next   = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && (count_reg < COUNT_STORE))
        begin
            store_reg[count_reg] <= s1_byte_reg;
        end
    end

    // final byte joins the stored ones
    always_comb
    begin
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            frame[i] = store_reg[i];
        end
        frame[FRAME_BYTES-1] = s1_byte_reg;
    end

    rfc_frame_judge u_judge (
        .complete (count_reg == COUNT_FINAL),
        .frame    (frame),
        .crc      (crc_reg),
        .verdict  (verdict)
    );

    // result register
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg  <= verdict.status;
            command_reg <= verdict.command_byte;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign command_byte = command_reg;

    assign is_command = (status_reg == ST_COMMAND_OK) || (status_reg == ST_COMMAND_ERROR);

    `RFC_ASSERT_NEXT(a_frame_restart, emit, (count_reg == '0) && (crc_reg == CRC_INIT))
    `RFC_ASSERT_NEXT(a_emit_shows, emit, out_valid_reg)
    `RFC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg)
    `RFC_ASSERT_NOW(a_cmd_zero, out_valid_reg && !is_command, command_reg == 8'h00)

endmodule

// ----- hw/rtl/rfc_frame_judge.sv -----
// ----------------------------------------------------------------------------
// rfc_frame_judge
// Classifies one complete reply frame: literal frames first, then CRC,
// header, address, type, length and trailer, then the response byte.
// ----------------------------------------------------------------------------
module rfc_frame_judge
    import rfc_pkg::*;
(
    input  logic        complete,
    input  frame_t      frame,
    input  logic [15:0] crc,
    output verdict_t    verdict
);

    logic crc_match;
    logic layout_match;

    assign crc_match = (frame[7] == crc[7:0]) && (frame[8] == crc[15:8]);

    assign layout_match = (frame[0] == HDR_SYNC) && (frame[1] == HDR_ZERO)
                       && (frame[2] == ADDR_HOST) && (frame[3] == TYPE_COMMAND)
                       && (frame[4] == LEN_COMMAND) && (frame[9] == TRAIL_FIRST)
                       && (frame[10] == TRAIL_SECOND);

    always_comb
    begin
        verdict.status       = ST_UNPACK_ERROR;
        verdict.command_byte = 8'h00;
        if (complete)
        begin
            if (frame == CRC_ERR_FRAME)
            begin
                verdict.status = ST_CRC_ERROR;
            end
            else if (frame == DATA_OK_FRAME)
            begin
                verdict.status = ST_DATA_OK;
            end
            else if (crc_match && layout_match)
            begin
                if (frame[6] == RESP_OK)
                begin
                    verdict.status       = ST_COMMAND_OK;
                    verdict.command_byte = frame[5];
                end
                else if (frame[6] == RESP_ERROR)
                begin
                    verdict.status       = ST_COMMAND_ERROR;
                    verdict.command_byte = frame[5];
                end
            end
        end
    end

endmodule

// ----- dv/reply_frame_checker_test.sv -----
// ----------------------------------------------------------------------------
// reply_frame_checker_test
// Feeds reply frames byte by byte into the checker, with random gaps on the
// input and random stalls on the output, and one long output hold-off that
// backs the block up. A predictor tracks the byte count, the stored frame and
// the CRC, and works out the status of each frame. The monitor compares every
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module reply_frame_checker_test
    import rfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 660;
    localparam int SHORT_BURST  = 24;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [7:0]          data_byte    = 8'h00;
    logic                last_byte    = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [7:0]          command_byte;

    logic                hold_off     = 1'b0;
    logic                idle_ok      = 1'b0;

    rx_item_t            send_q[$];
    logic [7:0]          frame_buf[$];
    rx_item_t            next_item;
    int                  gap_left     = 0;
    int                  stall_left   = 0;
    int                  directed_len = 0;
    int                  target_len   = 0;
    int                  kind;
    int                  accepted_bytes = 0;
    int                  quiet_cycles   = 0;
    int                  errors         = 0;

    logic [3:0]          rx_count     = '0;
    frame_t              rx_frame     = '0;
    logic [15:0]         rx_crc       = CRC_INIT;
    verdict_t            verdicts[$];
    verdict_t            want;

    reply_frame_checker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .command_byte (command_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // CCITT update, one input bit at a time, MSB first
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic verdict_t judge_frame();
        verdict_t v;
        v.status       = ST_UNPACK_ERROR;
        v.command_byte = 8'h00;
        if (rx_count != FRAME_BYTES)
            return v;
        if (rx_frame == CRC_ERR_FRAME)
            v.status = ST_CRC_ERROR;
        else if (rx_frame == DATA_OK_FRAME)
            v.status = ST_DATA_OK;
        else if ({rx_frame[8], rx_frame[7]} == rx_crc &&
                 rx_frame[0] == HDR_SYNC && rx_frame[1] == HDR_ZERO &&
                 rx_frame[2] == ADDR_HOST && rx_frame[3] == TYPE_COMMAND &&
                 rx_frame[4] == LEN_COMMAND && rx_frame[9] == TRAIL_FIRST &&
                 rx_frame[10] == TRAIL_SECOND)
        begin
            if (rx_frame[6] == RESP_OK)
            begin
                v.status       = ST_COMMAND_OK;
                v.command_byte = rx_frame[5];
            end
            else if (rx_frame[6] == RESP_ERROR)
            begin
                v.status       = ST_COMMAND_ERROR;
                v.command_byte = rx_frame[5];
            end
        end
        return v;
    endfunction

    function automatic void take_byte(logic [7:0] b, logic last);
        if (rx_count < FRAME_BYTES)
            rx_frame[rx_count] = b;
        if (rx_count < CRC_BYTES)
            rx_crc = crc16_step(rx_crc, b);
        if (rx_count < COUNT_SAT)
            rx_count++;
        if (last)
        begin
            verdicts = {verdicts, judge_frame()};
            rx_count = '0;
            rx_crc   = CRC_INIT;
        end
    endfunction

    function automatic void append_byte(logic [7:0] b);
        frame_buf = {frame_buf, b};
    endfunction

    function automatic void build_reply(logic [7:0] kind_byte, logic [7:0] cmd,
                                        logic [7:0] resp);
        logic [15:0] crc;
        frame_buf = {HDR_SYNC, HDR_ZERO, ADDR_HOST, kind_byte, LEN_COMMAND, cmd, resp};
        crc = CRC_INIT;
        foreach (frame_buf[i])
            crc = crc16_step(crc, frame_buf[i]);
        append_byte(crc[7:0]);
        append_byte(crc[15:8]);
        append_byte(TRAIL_FIRST);
        append_byte(TRAIL_SECOND);
    endfunction

    function automatic void build_literal(frame_t f);
        frame_buf.delete();
        for (int i = 0; i < FRAME_BYTES; i++)
            append_byte(f[i]);
    endfunction

    function automatic void build_noise(int len);
        frame_buf.delete();
        repeat (len)
            append_byte(8'($urandom));
    endfunction

    function automatic logic [7:0] pick_resp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return RESP_OK;
        if (r < 8)
            return RESP_ERROR;
        return 8'($urandom);
    endfunction

    function automatic void send_frame();
        rx_item_t item;
        foreach (frame_buf[i])
        begin
            item   = {frame_buf[i], 1'(i == frame_buf.size() - 1)};
            send_q = {send_q, item};
        end
    endfunction

    // driver: hold while stalled, otherwise idle for a burst or advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
            gap_left   = 0;
        end
        else
        begin
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (idle_ok && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    next_item = send_q.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= next_item.data;
                    last_byte <= next_item.last;
                end
                else
                    in_valid <= 1'b0;
            end
            idle_ok <= send_q.size() > CALM_TAIL && (send_q.size() / 90) % 3 != 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left > 0)
                stall_left--;
            else if (idle_ok && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 5);
            out_stall <= hold_off || stall_left > 0;
        end
    end

    // monitor: predict on every accepted byte, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                take_byte(data_byte, last_byte);
                accepted_bytes++;
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts.size() == 0)
                begin
                    $error("unexpected result: status %0d, command_byte 0x%02h",
                           status, command_byte);
                    errors++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (command_byte !== want.command_byte)
                    begin
                        $error("command_byte: expected 0x%02h, actual 0x%02h",
                               want.command_byte, command_byte);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // long output hold-off while single-byte frames keep coming
    initial
    begin
        wait (rst_n);
        wait (directed_len > 0 && accepted_bytes >= directed_len);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        build_literal(CRC_ERR_FRAME);
        send_frame();
        build_literal(DATA_OK_FRAME);
        send_frame();
        build_reply(TYPE_COMMAND, 8'hff, RESP_OK);
        send_frame();
        build_reply(TYPE_COMMAND, 8'h00, RESP_ERROR);
        send_frame();
        build_reply(TYPE_COMMAND, 8'h5a, 8'h7e);
        send_frame();
        build_reply(TYPE_COMMAND, 8'h3c, RESP_OK);
        frame_buf[7] ^= 8'h01;
        send_frame();
        build_reply(8'h33, 8'h60, RESP_ERROR);
        send_frame();
        build_noise(1);
        frame_buf[0] = 8'hff;
        send_frame();
        build_reply(TYPE_COMMAND, 8'h81, RESP_OK);
        void'(frame_buf.pop_back());
        send_frame();
        build_literal(CRC_ERR_FRAME);
        append_byte(8'h00);
        send_frame();
        build_reply(TYPE_COMMAND, 8'h42, RESP_OK);
        repeat (5) append_byte(8'($urandom));
        send_frame();
        directed_len = send_q.size();

        repeat (SHORT_BURST)
        begin
            build_noise(1);
            send_frame();
        end

        target_len = send_q.size() + RANDOM_BYTES;
        while (send_q.size() < target_len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
                build_reply(TYPE_COMMAND, 8'($urandom), pick_resp());
            else if (kind < 65)
            begin
                build_reply(TYPE_COMMAND, 8'($urandom), pick_resp());
                frame_buf[$urandom_range(0, FRAME_BYTES - 1)] ^= 8'($urandom_range(1, 255));
            end
            else if (kind < 73)
            begin
                build_literal($urandom_range(0, 1) ? CRC_ERR_FRAME : DATA_OK_FRAME);
                if ($urandom_range(0, 2) == 0)
                    frame_buf[$urandom_range(0, FRAME_BYTES - 1)] ^=
                        8'($urandom_range(1, 255));
            end
            else if (kind < 85)
                build_noise($urandom_range(1, 16));
            else
            begin
                build_reply(TYPE_COMMAND, 8'($urandom), pick_resp());
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
                else
                    repeat ($urandom_range(1, 10)) void'(frame_buf.pop_back());
            end
            send_frame();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (send_q.size() == 0 && !in_valid);
        wait (verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdicts.size() != 0)
        begin
            $error("%0d expected results never arrived", verdicts.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
